// ===== hdl/pbl_pkg.sv =====
package pbl_pkg;

  // Default number of slots in the list store.
  localparam int unsigned CapacityDefault = 32;

  // Field widths fixed by the interface.
  localparam int unsigned ActionWidth   = 3;
  localparam int unsigned PositionWidth = 6;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned CountWidth    = 6;

  // Action codes.
  localparam logic [ActionWidth-1:0] ACT_INS_END   = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_INS_FRONT = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_INS_AT    = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_DEL_END   = 3'd4;
  localparam logic [ActionWidth-1:0] ACT_DEL_AT    = 3'd5;
  localparam logic [ActionWidth-1:0] ACT_READ_AT   = 3'd6;

  // Status codes.
  localparam logic [StatusWidth-1:0] ST_OK     = 2'd0;
  localparam logic [StatusWidth-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL   = 2'd2;
  localparam logic [StatusWidth-1:0] ST_EMPTY  = 2'd3;

  // One input word.
  typedef struct packed {
    logic [ActionWidth-1:0]   action;
    logic [PositionWidth-1:0] position;
    logic [ByteWidth-1:0]     value;
  } pbl_in_t;

  // One result word.
  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  count;
    logic [ByteWidth-1:0]   read_value;
  } pbl_out_t;

  // Content of the input register as seen by the list logic.
  typedef struct packed {
    logic    valid;
    pbl_in_t item;
  } pbl_stage_t;

endpackage

// ===== hdl/pbl_in_stage.sv =====
module pbl_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbl_pkg::pbl_in_t    in_data_i,
  input  logic                advance_i,
  output pbl_pkg::pbl_stage_t stage_o
);

  logic             valid_q, valid_d;
  pbl_pkg::pbl_in_t item_q;

  // The register takes a new word when empty or when its word moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== hdl/pbl_core.sv =====
module pbl_core #(
  parameter int unsigned CAPACITY = pbl_pkg::CapacityDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  pbl_pkg::pbl_in_t  item_i,
  output pbl_pkg::pbl_out_t result_o
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = pbl_pkg::PositionWidth;
  localparam int unsigned CW = ((LW > PW) ? LW : PW) + 1;

  logic [pbl_pkg::ByteWidth-1:0]   slots_q [CAPACITY];
  logic [pbl_pkg::ByteWidth-1:0]   slots_d [CAPACITY];
  logic [LW-1:0]                   len_q, len_d;
  logic [CW-1:0]                   len_w, pos_w, idx_w, len_next_w;
  logic                            do_ins, do_del;
  logic                            full, empty, pos_bad_ins, pos_bad_sel;
  logic [pbl_pkg::StatusWidth-1:0] status;
  logic [pbl_pkg::ByteWidth-1:0]   rd;

  // Compare length and position in one common width.
  assign len_w       = CW'(len_q);
  assign pos_w       = CW'(item_i.position);
  assign full        = (len_w == CW'(CAPACITY));
  assign empty       = (len_w == '0);
  assign pos_bad_ins = (pos_w == '0) || (pos_w > len_w + CW'(1));
  assign pos_bad_sel = (pos_w == '0) || (pos_w > len_w);

  // Action decode: pick the slot index of the change, the status and the read value.
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    idx_w  = '0;
    status = pbl_pkg::ST_OK;
    rd     = '0;
    unique case (item_i.action)
      pbl_pkg::ACT_INS_END: begin
        if (full) begin
          status = pbl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx_w  = len_w;
        end
      end
      pbl_pkg::ACT_INS_FRONT: begin
        if (full) begin
          status = pbl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      pbl_pkg::ACT_INS_AT: begin
        if (pos_bad_ins) begin
          status = pbl_pkg::ST_BADPOS;
        end else if (full) begin
          status = pbl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx_w  = pos_w - CW'(1);
        end
      end
      pbl_pkg::ACT_DEL_FRONT: begin
        if (empty) begin
          status = pbl_pkg::ST_EMPTY;
        end else begin
          do_del = 1'b1;
        end
      end
      pbl_pkg::ACT_DEL_END: begin
        if (empty) begin
          status = pbl_pkg::ST_EMPTY;
        end else begin
          do_del = 1'b1;
          idx_w  = len_w - CW'(1);
        end
      end
      pbl_pkg::ACT_DEL_AT: begin
        if (empty) begin
          status = pbl_pkg::ST_EMPTY;
        end else if (pos_bad_sel) begin
          status = pbl_pkg::ST_BADPOS;
        end else begin
          do_del = 1'b1;
          idx_w  = pos_w - CW'(1);
        end
      end
      pbl_pkg::ACT_READ_AT: begin
        if (pos_bad_sel) begin
          status = pbl_pkg::ST_BADPOS;
        end else begin
          rd = slots_q[IW'(pos_w - CW'(1))];
        end
      end
      default: begin
        status = pbl_pkg::ST_BADPOS;
      end
    endcase
  end

  // Length after the action.
  always_comb begin
    if (do_ins) begin
      len_next_w = len_w + CW'(1);
    end else if (do_del) begin
      len_next_w = len_w - CW'(1);
    end else begin
      len_next_w = len_w;
    end
  end

  assign len_d = advance_i ? LW'(len_next_w) : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Each slot moves by at most one place: up on insert, down on delete.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    logic [pbl_pkg::ByteWidth-1:0] below, above;

    if (k > 0) begin : g_below
      assign below = slots_q[k-1];
    end else begin : g_no_below
      assign below = '0;
    end

    if (k < CAPACITY - 1) begin : g_above
      assign above = slots_q[k+1];
    end else begin : g_no_above
      assign above = slots_q[k];
    end

    always_comb begin
      slots_d[k] = slots_q[k];
      if (advance_i && do_ins) begin
        if (CW'(k) == idx_w) begin
          slots_d[k] = item_i.value;
        end else if (CW'(k) > idx_w) begin
          slots_d[k] = below;
        end
      end else if (advance_i && do_del && (CW'(k) >= idx_w)) begin
        slots_d[k] = above;
      end
    end

    always_ff @(posedge clk_i) begin
      slots_q[k] <= slots_d[k];
    end
  end

  assign result_o.status     = status;
  assign result_o.count      = len_next_w[pbl_pkg::CountWidth-1:0];
  assign result_o.read_value = rd;

  // The length never passes the store size.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(len_q) <= CW'(CAPACITY))
    else $error("list length above capacity");

  // A successful insert grows the list by one.
  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && do_ins |=> CW'(len_q) == CW'($past(len_q)) + CW'(1))
    else $error("insert did not grow the list");

  // A rejected action leaves the length alone.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (status != pbl_pkg::ST_OK) |=> len_q == $past(len_q))
    else $error("rejected action changed the length");

  // Insert and delete never happen together, and errors change nothing.
  a_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_ins && do_del) && !((do_ins || do_del) && (status != pbl_pkg::ST_OK)))
    else $error("conflicting list update");

endmodule

// ===== hdl/pbl_out_stage.sv =====
module pbl_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pbl_pkg::pbl_out_t result_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbl_pkg::pbl_out_t out_data_o
);

  logic              valid_q, valid_d;
  pbl_pkg::pbl_out_t data_q;

  // A new result may enter when the register is empty or being drained.
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hdl/positional_byte_list_top.sv =====
// Path: a word is taken into the input register; its result is loaded into the output register when the word advances.
// Throughput: one word per cycle while the result register has room; the slot array updates every slot in parallel.
// Back-pressure on the result side stalls the input register and also holds the list state.
// Reset (rst_ni low, asynchronous): length cleared to zero, both registers emptied.
// Slot contents are not cleared by reset; only slots below the length are ever read.
module positional_byte_list_top #(
  parameter int unsigned CAPACITY = pbl_pkg::CapacityDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbl_pkg::pbl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbl_pkg::pbl_out_t out_data_o
);

  pbl_pkg::pbl_stage_t stage;
  pbl_pkg::pbl_out_t   result;
  logic                can_load;
  logic                advance;

  // A word leaves the input register when the result register has room.
  assign advance = stage.valid && can_load;

  pbl_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  pbl_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage.item),
    .result_o  (result)
  );

  pbl_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
